// ===== rtl/core/ldbr_pkg.sv =====
// Shared types and constants for the longest distinct byte run block.
// No dependencies; used by ldbr_table and longest_distinct_byte_run.
`default_nettype none

package ldbr_pkg;

  // Width of the reported lengths.
  localparam int unsigned LenW = 16;

  // Port controls for the last-seen table.
  typedef struct packed {
    logic rd_en;   // capture read data at the read address
    logic wr_en;   // write position and set the mark
    logic clr;     // drop every mark before the write
  } tbl_ctrl_t;

endpackage : ldbr_pkg

`default_nettype wire

// ===== rtl/core/ldbr_table.sv =====
// Last-seen position table: one synchronous RAM plus a mark bit per byte value.
// Depends on ldbr_pkg (tbl_ctrl_t).
`default_nettype none

module ldbr_table #(
  parameter int unsigned POS_BITS = 16,
  parameter int unsigned ALPHABET = 256,
  parameter int unsigned AW       = (ALPHABET > 1) ? $clog2(ALPHABET) : 1
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  ldbr_pkg::tbl_ctrl_t    ctrl_i,
  input  wire  [AW-1:0]          raddr_i,
  input  wire  [AW-1:0]          waddr_i,
  input  wire  [POS_BITS-1:0]    wdata_i,
  output logic [POS_BITS-1:0]    rdata_o,
  output logic                   vld_o
);

  logic [POS_BITS-1:0] mem [ALPHABET];
  logic [POS_BITS-1:0] rdata_q;
  logic [AW-1:0]       raddr_q;
  logic [ALPHABET-1:0] vld_q, vld_d;

  // Read-before-write on a shared address; the caller forwards.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
      raddr_q <= raddr_i;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (ctrl_i.wr_en) begin
      if (ctrl_i.clr) begin
        vld_d = '0;
      end
      vld_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Mark of the held read address reflects every committed write.
  assign rdata_o = rdata_q;
  assign vld_o   = vld_q[raddr_q];

endmodule : ldbr_table

`default_nettype wire

// ===== rtl/core/longest_distinct_byte_run.sv =====
// Top level: longest run of distinct bytes over a byte stream.
// Depends on ldbr_pkg and ldbr_table.
//
//   channel   dir  tdata (low bit first)                  tuser
//   s_axis    in   in_byte[7:0]                           first_of_string
//   m_axis    out  longest_so_far[15:0], window_length    overflow
//
// One beat per cycle sustained while the output is not stalled. A byte waits
// in the scoring stage on its table read (registered RAM output), then is
// scored and written back as it moves into the output register.
// A repeat of the byte just committed is forwarded past the RAM read.
// Reset clears all marks, counters and valid flags; the RAM itself is left
// as is. A stalled output holds the scoring stage, which holds the input.
`default_nettype none

module longest_distinct_byte_run #(
  parameter int unsigned POS_BITS = 16,
  parameter int unsigned ALPHABET = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire         s_axis_tuser,   // [0] first_of_string
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] longest_so_far, [31:16] window_length
  output logic        m_axis_tuser    // [0] overflow
);

  localparam int unsigned AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned LW = ldbr_pkg::LenW;
  localparam int unsigned EW = (POS_BITS > LW) ? POS_BITS : LW;
  localparam logic [POS_BITS-1:0] PosMax = {POS_BITS{1'b1}};
  localparam logic [AW-1:0] SymMax = AW'(ALPHABET - 1);

  // Byte saturated into the alphabet.
  logic [AW-1:0] in_sym;
  always_comb begin
    if ({1'b0, s_axis_tdata} > 9'(ALPHABET - 1)) begin
      in_sym = SymMax;
    end else begin
      in_sym = s_axis_tdata[AW-1:0];
    end
  end

  // Scoring stage (byte waiting on its table read).
  logic          s1_vld_q;
  logic [AW-1:0] s1_sym_q;
  logic          s1_first_q;

  logic out_vld_q;
  logic s1_move, s_acc;

  assign s1_move       = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_move;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_sym_q   <= in_sym;
      s1_first_q <= s_axis_tuser;
    end
  end

  // String state, updated as a byte commits.
  logic [POS_BITS-1:0] pos_q, ws_q, best_q;
  logic                ovf_q;

  // Last committed write, for the read that overlapped it.
  logic                fwd_vld_q;
  logic [AW-1:0]       fwd_sym_q;
  logic [POS_BITS-1:0] fwd_pos_q;

  ldbr_pkg::tbl_ctrl_t tbl_ctrl;
  logic [POS_BITS-1:0] tbl_rdata;
  logic                tbl_vld;

  // Scoring.
  logic [POS_BITS-1:0] pos_cur, ws_cur, best_cur, here, last, ws_d, win, best_d;
  logic                ovf_d, seen;

  always_comb begin
    pos_cur  = s1_first_q ? '0 : pos_q;
    ws_cur   = s1_first_q ? '0 : ws_q;
    best_cur = s1_first_q ? '0 : best_q;
    ovf_d    = s1_first_q ? 1'b0 : ovf_q;
    if (pos_cur == PosMax) begin
      here  = PosMax;
      ovf_d = 1'b1;
    end else begin
      here = pos_cur + 1'b1;
    end
    seen = tbl_vld && !s1_first_q;
    last = (fwd_vld_q && (fwd_sym_q == s1_sym_q)) ? fwd_pos_q : tbl_rdata;
    ws_d = (seen && (last > ws_cur)) ? last : ws_cur;
    win  = (here >= ws_d) ? (here - ws_d) : '0;
    best_d = (win > best_cur) ? win : best_cur;
  end

  always_comb begin
    tbl_ctrl.rd_en = s_acc;
    tbl_ctrl.wr_en = s1_move;
    tbl_ctrl.clr   = s1_first_q;
  end

  ldbr_table #(
    .POS_BITS (POS_BITS),
    .ALPHABET (ALPHABET),
    .AW       (AW)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tbl_ctrl),
    .raddr_i (in_sym),
    .waddr_i (s1_sym_q),
    .wdata_i (here),
    .rdata_o (tbl_rdata),
    .vld_o   (tbl_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ws_q      <= '0;
      best_q    <= '0;
      ovf_q     <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else if (s1_move) begin
      pos_q     <= here;
      ws_q      <= ws_d;
      best_q    <= best_d;
      ovf_q     <= ovf_d;
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      fwd_sym_q <= s1_sym_q;
      fwd_pos_q <= here;
    end
  end

  // Clip lengths to the report width.
  logic [EW-1:0] best_x, win_x;
  logic          best_clip, win_clip;
  logic [LW-1:0] best_r, win_r;

  always_comb begin
    best_x    = EW'(best_d);
    win_x     = EW'(win);
    best_clip = best_x > EW'({LW{1'b1}});
    win_clip  = win_x > EW'({LW{1'b1}});
    best_r    = best_clip ? {LW{1'b1}} : best_x[LW-1:0];
    win_r     = win_clip ? {LW{1'b1}} : win_x[LW-1:0];
  end

  // Output register.
  logic [31:0] out_data_q;
  logic        out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_move) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= {win_r, best_r};
      out_ovf_q  <= ovf_d || best_clip || win_clip;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule : longest_distinct_byte_run

`default_nettype wire
